// File: rtl/wstb_pkg.sv
// Shared types and opcode constants for the wrapping software timer bank.
// No dependencies; used by every module of the block.
package wstb_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_ATTACH  = 3'd1;
    localparam logic [2:0] OP_SET     = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_DETACH  = 3'd4;
    localparam logic [2:0] OP_POLL    = 3'd5;

    typedef enum logic [2:0] {
        K_TICK    = 3'd0,
        K_ATTACH  = 3'd1,
        K_SET     = 3'd2,
        K_RESTART = 3'd3,
        K_DETACH  = 3'd4,
        K_POLL    = 3'd5,
        K_NOP     = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  idx_ok;
    } cmd_ctl_t;

endpackage

// File: rtl/wstb_front.sv
// Front end of the timer bank: takes command beats, classifies them and
// holds them in a two-entry queue for the back end. Depends on wstb_pkg.
module wstb_front #(
    parameter int TIMERS    = 8,
    parameter int TIME_BITS = 32,
    parameter int IW        = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2:0]           opcode,
    input  logic [2:0]           timer_index,
    input  logic [31:0]          amount,
    output logic                 busy,
    output logic                 q_valid,
    output wstb_pkg::cmd_ctl_t   q_ctl,
    output logic [IW-1:0]        q_idx,
    output logic [TIME_BITS-1:0] q_amt,
    input  logic                 q_pop
);

    wstb_pkg::cmd_ctl_t   ctl_mem [2];
    logic [IW-1:0]        idx_mem [2];
    logic [TIME_BITS-1:0] amt_mem [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic                 push;
    logic                 idx_ok;
    logic [IW+2:0]        idx_wide;
    logic [TIME_BITS+31:0] amt_wide;
    wstb_pkg::cmd_ctl_t   ctl_in;

    assign busy    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign push    = start && !busy;

    assign idx_wide = {{IW{1'b0}}, timer_index};
    assign amt_wide = {{TIME_BITS{1'b0}}, amount};
    assign idx_ok   = ({1'b0, idx_wide} < (IW + 4)'(TIMERS));

    always_comb
    begin
        ctl_in.idx_ok = idx_ok;
        ctl_in.kind   = wstb_pkg::K_NOP;
        if (opcode == wstb_pkg::OP_TICK)
        begin
            ctl_in.kind = wstb_pkg::K_TICK;
        end
        else if (idx_ok)
        begin
            case (opcode)
                wstb_pkg::OP_ATTACH:  ctl_in.kind = wstb_pkg::K_ATTACH;
                wstb_pkg::OP_SET:     ctl_in.kind = wstb_pkg::K_SET;
                wstb_pkg::OP_RESTART: ctl_in.kind = wstb_pkg::K_RESTART;
                wstb_pkg::OP_DETACH:  ctl_in.kind = wstb_pkg::K_DETACH;
                wstb_pkg::OP_POLL:    ctl_in.kind = wstb_pkg::K_POLL;
                default:              ctl_in.kind = wstb_pkg::K_NOP;
            endcase
        end
    end

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg] <= ctl_in;
            idx_mem[wr_ptr_reg] <= idx_wide[IW-1:0];
            amt_mem[wr_ptr_reg] <= amt_wide[TIME_BITS-1:0];
        end
    end

    assign q_ctl = ctl_mem[rd_ptr_reg];
    assign q_idx = idx_mem[rd_ptr_reg];
    assign q_amt = amt_mem[rd_ptr_reg];

endmodule

// File: rtl/wstb_back.sv
// Back end of the timer bank: holds the clock and the per-timer state and
// carries out one queued command per cycle. Depends on wstb_pkg.
module wstb_back #(
    parameter int TIMERS    = 8,
    parameter int TIME_BITS = 32,
    parameter int IW        = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  wstb_pkg::cmd_ctl_t   q_ctl,
    input  logic [IW-1:0]        q_idx,
    input  logic [TIME_BITS-1:0] q_amt,
    output logic                 q_pop,
    output logic                 done,
    output logic                 fired,
    output logic                 timer_attached,
    output logic [TIME_BITS-1:0] now_value
);

    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 att_reg [TIMERS];
    logic                 att_next [TIMERS];
    logic                 exp_reg [TIMERS];
    logic                 exp_next [TIMERS];
    logic                 ovf_reg [TIMERS];
    logic                 ovf_next [TIMERS];
    logic [TIME_BITS-1:0] dl_reg [TIMERS];
    logic [TIME_BITS-1:0] dl_next [TIMERS];
    logic [TIME_BITS-1:0] iv_reg [TIMERS];
    logic [TIME_BITS-1:0] iv_next [TIMERS];

    logic done_reg, done_next;
    logic fired_reg, fired_next;
    logic att_out_reg, att_out_next;

    logic                 go;
    logic                 tick_go;
    logic                 wrapped;
    logic [TIME_BITS-1:0] now_sum;
    logic                 att_s;
    logic                 exp_s;
    logic [TIME_BITS-1:0] iv_s;
    logic [TIME_BITS-1:0] iv_use;
    logic [TIME_BITS-1:0] dl_new;
    logic                 ovf_new;
    logic                 do_restart;
    logic                 do_attach;
    logic                 do_detach;
    logic                 do_set;

    assign q_pop = q_valid;
    assign go    = q_valid;

    assign now_sum = now_reg + q_amt;
    assign wrapped = !(now_sum > now_reg);
    assign tick_go = go && (q_ctl.kind == wstb_pkg::K_TICK) && (q_amt != '0);

    assign att_s   = att_reg[q_idx];
    assign exp_s   = exp_reg[q_idx];
    assign iv_s    = iv_reg[q_idx];
    assign iv_use  = (q_ctl.kind == wstb_pkg::K_SET) ? q_amt : iv_s;
    assign dl_new  = now_reg + iv_use;
    assign ovf_new = !(dl_new > now_reg);

    assign do_attach  = go && (q_ctl.kind == wstb_pkg::K_ATTACH);
    assign do_detach  = go && (q_ctl.kind == wstb_pkg::K_DETACH) && att_s;
    assign do_set     = go && (q_ctl.kind == wstb_pkg::K_SET) && att_s;
    assign do_restart = go && att_s &&
                        ((q_ctl.kind == wstb_pkg::K_SET) ||
                         (q_ctl.kind == wstb_pkg::K_RESTART) ||
                         ((q_ctl.kind == wstb_pkg::K_POLL) && exp_s));

    always_comb
    begin
        now_next = tick_go ? now_sum : now_reg;
        for (int i = 0; i < TIMERS; i++)
        begin
            att_next[i] = att_reg[i];
            exp_next[i] = exp_reg[i];
            ovf_next[i] = ovf_reg[i];
            dl_next[i]  = dl_reg[i];
            iv_next[i]  = iv_reg[i];
            if (tick_go && att_reg[i] && !exp_reg[i])
            begin
                if (wrapped && ovf_reg[i])
                begin
                    ovf_next[i] = 1'b0;
                    exp_next[i] = (now_sum >= dl_reg[i]);
                end
                else if (wrapped)
                begin
                    exp_next[i] = 1'b1;
                end
                else if (!ovf_reg[i])
                begin
                    exp_next[i] = (now_sum >= dl_reg[i]);
                end
            end
            if (q_idx == IW'(i))
            begin
                if (do_attach)
                begin
                    att_next[i] = 1'b1;
                    exp_next[i] = 1'b1;
                    ovf_next[i] = 1'b0;
                    dl_next[i]  = '0;
                    iv_next[i]  = '0;
                end
                else if (do_detach)
                begin
                    att_next[i] = 1'b0;
                    exp_next[i] = 1'b0;
                    ovf_next[i] = 1'b0;
                    dl_next[i]  = '0;
                    iv_next[i]  = '0;
                end
                else if (do_restart)
                begin
                    dl_next[i]  = dl_new;
                    exp_next[i] = 1'b0;
                    ovf_next[i] = ovf_new;
                    if (do_set)
                    begin
                        iv_next[i] = q_amt;
                    end
                end
            end
        end
    end

    always_comb
    begin
        done_next  = go;
        fired_next = go && (q_ctl.kind == wstb_pkg::K_POLL) && att_s && exp_s;
        case (q_ctl.kind)
            wstb_pkg::K_ATTACH: att_out_next = q_ctl.idx_ok;
            wstb_pkg::K_DETACH: att_out_next = 1'b0;
            default:            att_out_next = q_ctl.idx_ok && att_s;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg   <= '0;
            done_reg  <= 1'b0;
            fired_reg <= 1'b0;
            for (int i = 0; i < TIMERS; i++)
            begin
                att_reg[i] <= 1'b0;
                exp_reg[i] <= 1'b0;
                ovf_reg[i] <= 1'b0;
            end
        end
        else
        begin
            now_reg   <= now_next;
            done_reg  <= done_next;
            fired_reg <= fired_next;
            for (int i = 0; i < TIMERS; i++)
            begin
                att_reg[i] <= att_next[i];
                exp_reg[i] <= exp_next[i];
                ovf_reg[i] <= ovf_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        att_out_reg <= att_out_next;
        for (int i = 0; i < TIMERS; i++)
        begin
            dl_reg[i] <= dl_next[i];
            iv_reg[i] <= iv_next[i];
        end
    end

    assign done           = done_reg;
    assign fired          = fired_reg;
    assign timer_attached = att_out_reg;
    assign now_value      = now_reg;

endmodule

// File: rtl/wrapping_software_timer_bank.sv
// Top level of the wrapping software timer bank: front-end queue plus
// execution back end. Depends on wstb_pkg, wstb_front and wstb_back.
//
//   Channel   Handshake             Beat contents
//   command   start / busy          opcode, timer_index, amount
//   result    done (strobe only)    fired, timer_attached, now_time
//
// One command is carried out per cycle; a taken command is first written into the
// queue, and done and the result are registered as the back end carries it out.
// The back end updates every timer in parallel on a tick.
// The back end pops the two-entry queue every cycle, so it never fills and busy stays low.
// Reset clears the clock and all timer marks at once; no clearing pass follows.
// The receiver cannot stall: each result is shown for one cycle only.
module wrapping_software_timer_bank #(
    parameter int TIMERS    = 8,
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [2:0]  timer_index,
    input  logic [31:0] amount,
    output logic        done,
    output logic        fired,
    output logic        timer_attached,
    output logic [31:0] now_time
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    logic                  q_valid;
    logic                  q_pop;
    wstb_pkg::cmd_ctl_t    q_ctl;
    logic [IW-1:0]         q_idx;
    logic [TIME_BITS-1:0]  q_amt;
    logic [TIME_BITS-1:0]  now_value;
    logic [TIME_BITS+31:0] now_wide;

    wstb_front #(
        .TIMERS    (TIMERS),
        .TIME_BITS (TIME_BITS),
        .IW        (IW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .timer_index (timer_index),
        .amount      (amount),
        .busy        (busy),
        .q_valid     (q_valid),
        .q_ctl       (q_ctl),
        .q_idx       (q_idx),
        .q_amt       (q_amt),
        .q_pop       (q_pop)
    );

    wstb_back #(
        .TIMERS    (TIMERS),
        .TIME_BITS (TIME_BITS),
        .IW        (IW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ctl          (q_ctl),
        .q_idx          (q_idx),
        .q_amt          (q_amt),
        .q_pop          (q_pop),
        .done           (done),
        .fired          (fired),
        .timer_attached (timer_attached),
        .now_value      (now_value)
    );

    assign now_wide = {32'd0, now_value};
    assign now_time = now_wide[31:0];

endmodule
